@@ rtl/packet_protocol_byte_router_defines.svh @@
// ---------------------------------------------------------------------------
// packet_protocol_byte_router_defines.svh
// assertion macros for the checker file
// ---------------------------------------------------------------------------
`ifndef PACKET_PROTOCOL_BYTE_ROUTER_DEFINES_SVH
`define PACKET_PROTOCOL_BYTE_ROUTER_DEFINES_SVH

// clocked assertion, switched off while reset is asserted
`define PRB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// clocked assertion that also holds during reset
`define PRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/prb_pkg.sv @@
// ---------------------------------------------------------------------------
// prb_pkg
// types and constants of the protocol byte router
// ---------------------------------------------------------------------------
package prb_pkg;

  localparam int unsigned KeyWord  = 2;   // beat number holding the key byte
  localparam int unsigned KeyByte  = 7;   // byte lane of the key within that beat
  localparam int unsigned HeadIdxW = (KeyWord > 1) ? $clog2(KeyWord) : 1;
  localparam int unsigned HeldW    = $clog2(KeyWord + 2);
  localparam logic [HeldW-1:0] PassMark = HeldW'(KeyWord + 1);
  localparam logic [7:0] FullStrobe = 8'hff;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned PaddrW = 3;
  localparam logic RegProtocol = 1'b0;    // register index of protocol_value

  typedef struct packed {
    logic [63:0] beat_data;
    logic [7:0]  beat_strobe;
    logic        beat_last;
  } in_beat_t;

  typedef struct packed {
    logic        out_port;
    logic [63:0] out_data;
    logic [7:0]  out_strobe;
    logic        out_last;
    logic [31:0] packet_count;
  } out_beat_t;

  // one classified beat plus the head beats released in front of it
  typedef struct packed {
    logic [KeyWord-1:0][63:0] head;
    logic [HeldW-1:0]         held;
    logic                     port;
    logic [31:0]              count;
    logic [63:0]              data;
    logic [7:0]               strobe;
    logic                     last;
  } cmd_t;

endpackage

@@ rtl/prb_front.sv @@
// ---------------------------------------------------------------------------
// prb_front
// holds head beats, classifies on the key beat and issues release commands
// ---------------------------------------------------------------------------
module prb_front import prb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_beat_t beat_i,
  input  logic [7:0] protocol_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic [HeldW-1:0]         beat_index_q, beat_index_d;
  logic                     route_q, route_d;
  logic [31:0]              count_q, count_d;
  logic [KeyWord-1:0][63:0] head_q;
  logic                     head_we;
  logic                     key_match;

  assign key_match = (beat_i.beat_data[8*KeyByte +: 8] == protocol_i);

  always_comb begin
    beat_index_d = beat_index_q;
    route_d      = route_q;
    count_d      = count_q;
    head_we      = 1'b0;
    cmd_push_o   = 1'b0;
    cmd_o.head   = head_q;
    cmd_o.held   = '0;
    cmd_o.data   = beat_i.beat_data;
    cmd_o.strobe = beat_i.beat_strobe;
    cmd_o.last   = beat_i.beat_last;
    if (accept_i) begin
      priority if (beat_index_q == PassMark) begin
        cmd_push_o = 1'b1;
        if (beat_i.beat_last) begin
          beat_index_d = '0;
        end
      end else if (beat_index_q < HeldW'(KeyWord)) begin
        if (!beat_i.beat_last) begin
          head_we      = 1'b1;
          beat_index_d = beat_index_q + 1'b1;
        end else begin
          // short packet
          route_d      = 1'b1;
          count_d      = count_q + 32'd1;
          cmd_o.held   = beat_index_q;
          cmd_push_o   = 1'b1;
          beat_index_d = '0;
        end
      end else begin
        route_d      = !key_match;
        count_d      = count_q + 32'd1;
        cmd_o.held   = HeldW'(KeyWord);
        cmd_push_o   = 1'b1;
        beat_index_d = beat_i.beat_last ? '0 : PassMark;
      end
    end
    cmd_o.port  = route_d;
    cmd_o.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_index_q <= '0;
      route_q      <= 1'b0;
      count_q      <= '0;
    end else begin
      beat_index_q <= beat_index_d;
      route_q      <= route_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_q[beat_index_q[HeadIdxW-1:0]] <= beat_i.beat_data;
    end
  end

endmodule

@@ rtl/prb_queue.sv @@
// ---------------------------------------------------------------------------
// prb_queue
// short command queue between classifier and release stage
// ---------------------------------------------------------------------------
module prb_queue import prb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic valid_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/prb_back.sv @@
// ---------------------------------------------------------------------------
// prb_back
// expands each command into output beats through the output register
// ---------------------------------------------------------------------------
module prb_back import prb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      out_pop_i,
  output logic      out_valid_o,
  output out_beat_t out_beat_o
);

  logic [HeldW-1:0] sel_q, sel_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;
  logic             load;
  logic             head_phase;

  assign load       = cmd_valid_i && (!out_valid_q || out_pop_i);
  assign head_phase = (sel_q < cmd_i.held);

  always_comb begin
    out_d.out_port     = cmd_i.port;
    out_d.packet_count = cmd_i.count;
    if (head_phase) begin
      out_d.out_data   = cmd_i.head[sel_q[HeadIdxW-1:0]];
      out_d.out_strobe = FullStrobe;
      out_d.out_last   = 1'b0;
    end else begin
      out_d.out_data   = cmd_i.data;
      out_d.out_strobe = cmd_i.last ? cmd_i.strobe : FullStrobe;
      out_d.out_last   = cmd_i.last;
    end
    cmd_pop_o = load && !head_phase;
    sel_d     = sel_q;
    if (load) begin
      sel_d = head_phase ? sel_q + 1'b1 : '0;
    end
    out_valid_d = load ? 1'b1 : (out_pop_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

@@ rtl/packet_protocol_byte_router.sv @@
// ---------------------------------------------------------------------------
// packet_protocol_byte_router
// two-way stream classifier on the top byte of the key beat, cut-through
// ---------------------------------------------------------------------------
//  channel   direction  handshake            beat
//  input     in         push / full          in_beat_i  (data, strobe, last)
//  result    out        pop / empty          out_beat_o (port, data, strobe,
//                                                        last, packet count)
//  config    in/out     psel/penable/pready  protocol_value at address 0
//
//  one beat per cycle sustained while pop keeps up; a beat with output passes
//  the command queue, then the output register, before it shows on the result
//  ports; a key beat makes the release stage send the two held head beats in
//  front of it; the four-entry command queue absorbs this, held beats give
//  no output; full follows the queue, empty follows the output register
//  reset clears control state only; beats are taken from the first edge after it
// ---------------------------------------------------------------------------
module packet_protocol_byte_router import prb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input queue side
  input  logic              push,
  output logic              full,
  input  in_beat_t          in_beat_i,
  // result queue side
  input  logic              pop,
  output logic              empty,
  output out_beat_t         out_beat_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0] protocol_q;
  logic       in_accept;
  logic       cmd_push;
  cmd_t       cmd_in;
  cmd_t       cmd_out;
  logic       cmd_valid;
  logic       cmd_pop;
  logic       q_full;
  logic       out_valid;
  logic       reg_sel;

  // register file: one byte register, index taken from the word address
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == RegProtocol);
  assign prdata  = reg_sel ? {24'd0, protocol_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      protocol_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      protocol_q <= pwdata[7:0];
    end
  end

  // a beat is taken whenever the command queue has room
  assign full      = q_full;
  assign in_accept = push && !q_full;

  // front: head store, key compare, packet counter
  prb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .beat_i     (in_beat_i),
    .protocol_i (protocol_q),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // decoupling queue
  prb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_out),
    .full_o  (q_full),
    .valid_o (cmd_valid)
  );

  // back: release sequencer and output register
  prb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_pop_i   (pop),
    .out_valid_o (out_valid),
    .out_beat_o  (out_beat_o)
  );

  assign empty = !out_valid;

endmodule

@@ rtl/prb_checker.sv @@
// ---------------------------------------------------------------------------
// prb_checker
// port-level checks on the result side of the router
// ---------------------------------------------------------------------------
`include "packet_protocol_byte_router_defines.svh"

module prb_checker import prb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      pop_i,
  input logic      empty_i,
  input logic      pready_i,
  input out_beat_t out_beat_i
);

  // a shown beat holds until it is taken
  `PRB_ASSERT(a_hold, clk_i, rst_ni, (!empty_i && !pop_i) |=> (!empty_i && $stable(out_beat_i)), "result beat changed while stalled")

  // non-last beats always carry a full strobe
  `PRB_ASSERT(a_strobe, clk_i, rst_ni, (!empty_i && !out_beat_i.out_last) |-> (out_beat_i.out_strobe == FullStrobe), "non-last beat without full strobe")

  // beats of one packet share port and count
  `PRB_ASSERT(a_same_pkt, clk_i, rst_ni, (pop_i && !empty_i && !out_beat_i.out_last) |=> (empty_i || (out_beat_i.out_port == $past(out_beat_i.out_port) && out_beat_i.packet_count == $past(out_beat_i.packet_count))), "packet split across port or count")

  // the next packet carries the next count
  `PRB_ASSERT(a_next_pkt, clk_i, rst_ni, (pop_i && !empty_i && out_beat_i.out_last) |=> (empty_i || out_beat_i.packet_count == $past(out_beat_i.packet_count) + 32'd1), "packet count did not step by one")

  `PRB_ASSERT_ALWAYS(a_pready, clk_i, pready_i, "config port not ready")

endmodule

bind packet_protocol_byte_router prb_checker u_prb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pop_i      (pop),
  .empty_i    (empty),
  .pready_i   (pready),
  .out_beat_i (out_beat_o)
);

@@ tb/sv/packet_protocol_byte_router_test.sv @@
// ---------------------------------------------------------------------------
// packet_protocol_byte_router_test
// self-checking bench for the two-way protocol byte router
// ---------------------------------------------------------------------------
// packets of random length are pushed through the input queue while the
// result queue is popped on a stall pattern of its own; a behavioural copy
// of the router predicts every output beat (port, data, strobe, last and
// packet count) and each popped beat is checked against the oldest one.
// the protocol register is rewritten between phases, only with the block
// drained, and read back over the configuration port.
// ---------------------------------------------------------------------------
module packet_protocol_byte_router_test;
  timeunit 1ns;
  timeprecision 1ps;

  import prb_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandPhases = 6;

  // clock, reset and block inputs, all known from time zero
  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              push      = 1'b0;
  logic              pop       = 1'b0;
  in_beat_t          in_beat_i = '0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [PaddrW-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;

  logic              full;
  logic              empty;
  out_beat_t         out_beat_o;
  logic [31:0]       prdata;
  logic              pready;

  packet_protocol_byte_router i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_beat_i  (in_beat_i),
    .pop        (pop),
    .empty      (empty),
    .out_beat_o (out_beat_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // beats waiting to be pushed, and output beats the router owes us
  in_beat_t  pending_beats [$];
  out_beat_t expected_beats [$];

  // behavioural copy of the router state
  logic [7:0]       proto_q = 8'h00;
  logic [63:0]      head_q [KeyWord];
  logic [HeldW-1:0] held_q  = '0;
  logic             port_q  = 1'b0;
  logic [31:0]      count_q = '0;

  // idling knobs, changed between phases; hold_send also mid-phase
  int unsigned burst_max = 2;
  int unsigned gap_max   = 2;
  int unsigned stall_pct = 20;
  int unsigned stall_max = 3;
  bit          hold_send = 1'b0;

  // bookkeeping
  int unsigned cycles        = 0;
  int unsigned mismatches    = 0;
  int unsigned beats_queued  = 0;
  int unsigned beats_checked = 0;
  int unsigned port0_beats   = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left    = 1;
  int unsigned gap_left      = 0;
  int unsigned pop_run       = 0;
  out_beat_t   want_beat;

  // 12 ns clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  // one output beat on the current port; non-last beats get a full strobe
  task automatic queue_result(input logic [63:0] data, input logic [7:0] strobe,
                              input logic last);
    out_beat_t r;
    r.out_port     = port_q;
    r.out_data     = data;
    r.out_strobe   = last ? strobe : FullStrobe;
    r.out_last     = last;
    r.packet_count = count_q;
    expected_beats.push_back(r);
  endtask

  // advance the router copy by one accepted input beat
  task automatic route_beat(input in_beat_t b);
    int unsigned i;
    if (held_q == PassMark) begin
      // classified packet, cut straight through
      queue_result(b.beat_data, b.beat_strobe, b.beat_last);
      if (b.beat_last) held_q = '0;
    end else if (held_q < KeyWord) begin
      if (!b.beat_last) begin
        // head beat, held back with no output
        head_q[held_q] = b.beat_data;
        held_q = held_q + 1'b1;
      end else begin
        // short packet ends before the key beat: always the other port
        port_q  = 1'b1;
        count_q = count_q + 1'b1;
        for (i = 0; i < held_q; i++) queue_result(head_q[i], FullStrobe, 1'b0);
        queue_result(b.beat_data, b.beat_strobe, 1'b1);
        held_q = '0;
      end
    end else begin
      // key beat: classify on its top byte, release the head in front of it
      port_q  = (b.beat_data[8*KeyByte +: 8] == proto_q) ? 1'b0 : 1'b1;
      count_q = count_q + 1'b1;
      for (i = 0; i < KeyWord; i++) queue_result(head_q[i], FullStrobe, 1'b0);
      queue_result(b.beat_data, b.beat_strobe, b.beat_last);
      held_q = b.beat_last ? '0 : PassMark;
    end
  endtask

  // ------------------------------------------------------------------
  // input driver: bursts of random length with random gaps
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      in_beat_i <= '0;
    end else begin
      if (push && !full) begin
        // beat taken at this edge, predict from it
        route_beat(pending_beats.pop_front());
      end
      if (push && full) begin
        // back-pressure: keep the same beat on the port
      end else if (gap_left != 0) begin
        push     <= 1'b0;
        gap_left--;
      end else if (pending_beats.size() != 0 && !hold_send) begin
        push      <= 1'b1;
        in_beat_i <= pending_beats[0];
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(burst_max, 1);
          gap_left   = $urandom_range(gap_max, 0);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // output monitor and pop pattern
  // ------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, actual %p",
                   $time, out_beat_o);
        end else begin
          want_beat = expected_beats.pop_front();
          check_field("out_port", 64'(want_beat.out_port), 64'(out_beat_o.out_port));
          check_field("out_data", want_beat.out_data, out_beat_o.out_data);
          check_field("out_strobe", 64'(want_beat.out_strobe),
                      64'(out_beat_o.out_strobe));
          check_field("out_last", 64'(want_beat.out_last), 64'(out_beat_o.out_last));
          check_field("packet_count", 64'(want_beat.packet_count),
                      64'(out_beat_o.packet_count));
          beats_checked++;
          if (!want_beat.out_port) port0_beats++;
        end
      end
      // runs of pop high or low, stall share set per phase
      if (pop_run == 0) begin
        if ($urandom_range(99) < stall_pct) begin
          pop     <= 1'b0;
          pop_run = $urandom_range(stall_max, 1);
        end else begin
          pop     <= 1'b1;
          pop_run = $urandom_range(8, 1);
        end
      end else begin
        pop_run--;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: run exceeded %0d cycles, %0d beats still owed",
               $time, CycleLimit, expected_beats.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // configuration port access: setup cycle, then access until pready
  // ------------------------------------------------------------------
  task automatic cfg_access(input bit wr, input logic [PaddrW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (wr && addr[PaddrW-1:2] == RegProtocol) proto_q = wdata[7:0];
  endtask

  task automatic check_protocol_reg();
    logic [31:0] rd;
    cfg_access(1'b0, '0, '0, rd);
    if (rd !== {24'h0, proto_q}) begin
      mismatches++;
      $display("%0t: protocol_value readback mismatch, expected %0h, actual %0h",
               $time, {24'h0, proto_q}, rd);
    end
  endtask

  // random upper bits show that only the low byte is kept
  task automatic set_protocol(input logic [7:0] value);
    logic [31:0] rd;
    cfg_access(1'b1, '0, {24'($urandom_range(16777215)), value}, rd);
    settings_used++;
    check_protocol_reg();
  endtask

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  task automatic add_beat(input logic [63:0] data, input logic [7:0] strobe,
                          input logic last);
    in_beat_t b;
    b.beat_data   = data;
    b.beat_strobe = strobe;
    b.beat_last   = last;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // key < 0 leaves the key byte random
  task automatic queue_packet(input int unsigned len, input int key);
    logic [63:0] data;
    int unsigned n;
    for (n = 0; n < len; n++) begin
      data = {$urandom, $urandom};
      if (n == KeyWord && key >= 0) data[8*KeyByte +: 8] = key[7:0];
      add_beat(data, 8'($urandom_range(255)), n == len - 1);
    end
  endtask

  // wait until every queued beat is in and every owed beat is out
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || push || expected_beats.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  // ------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------
  initial begin
    logic [31:0] rd;
    int unsigned phase;
    int unsigned fill;
    int unsigned len;
    int unsigned pick;

    $timeformat(-9, 3, " ns", 0);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value, then a real setting and a write to an unused address
    check_protocol_reg();
    set_protocol(8'ha5);
    cfg_access(1'b1, PaddrW'(4), $urandom, rd);
    check_protocol_reg();

    // directed packets
    @(negedge clk_i);
    add_beat('1, 8'h00, 1'b1);                 // single-beat packet
    add_beat('0, 8'h00, 1'b0);                 // two-beat packet, short
    add_beat('1, 8'hff, 1'b1);
    queue_packet(3, int'(proto_q));            // key beat is the last one
    queue_packet(5, int'(proto_q));            // match, cut-through tail
    queue_packet(4, int'(proto_q ^ 8'h01));    // near miss on the key byte
    add_beat('0, 8'hff, 1'b0);                 // all-ones key beat, no match
    add_beat('1, 8'h00, 1'b0);
    add_beat('1, 8'h00, 1'b0);
    add_beat('0, 8'h01, 1'b1);
    wait_drained();

    // random phases, each under its own register value and idling pattern
    for (phase = 0; phase < RandPhases; phase++) begin
      case (phase)
        0: begin burst_max = 64; gap_max = 0; stall_pct = 0;  stall_max = 1;  end
        1: begin burst_max = 4;  gap_max = 3; stall_pct = 30; stall_max = 4;  end
        2: begin burst_max = 1;  gap_max = 6; stall_pct = 10; stall_max = 2;  end
        3: begin burst_max = 16; gap_max = 2; stall_pct = 60; stall_max = 10; end
        4: begin burst_max = 8;  gap_max = 1; stall_pct = 0;  stall_max = 1;  end
        default: begin burst_max = 3; gap_max = 4; stall_pct = 40; stall_max = 6; end
      endcase
      case (phase)
        0:       set_protocol(8'h00);
        1:       set_protocol(8'hff);
        default: set_protocol(8'($urandom_range(255)));
      endcase

      @(negedge clk_i);
      fill = 0;
      while (fill < 50) begin
        pick = $urandom_range(99);
        if (pick < 10)      len = 1;
        else if (pick < 20) len = 2;
        else if (pick < 30) len = 3;
        else if (pick < 88) len = $urandom_range(8, 4);
        else                len = $urandom_range(24, 9);
        // about half the packets carry the configured byte
        queue_packet(len, $urandom_range(1) ? int'(proto_q) : -1);
        fill += len;
      end

      if (phase == 3) begin
        // sender holds off mid-phase until the result side has caught up
        do @(negedge clk_i); while (pending_beats.size() > fill / 2);
        hold_send = 1'b1;
        do @(negedge clk_i); while (push || expected_beats.size() != 0);
        repeat (5) @(negedge clk_i);
        hold_send = 1'b0;
      end
      wait_drained();
    end

    $display("covered %0d input beats in %0d packets under %0d protocol settings",
             beats_queued, count_q, settings_used);
    $display("%0d result beats checked, %0d on port 0, %0d on port 1, %0d mismatches",
             beats_checked, port0_beats, beats_checked - port0_beats, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
